@@ rtl/ita_pkg.sv @@
// Shared types, sizes and character helpers for the integer to ASCII converter.
// Used by every module in this folder; it depends on nothing else.
package ita_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W      = 4 * NUM_DIGITS;
    localparam int SEL_W      = $clog2(NUM_DIGITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_LOWER_A = 7'd97;
    localparam logic [6:0] CH_UPPER_A = 7'd65;
    localparam logic [6:0] CH_MINUS   = 7'd45;

    typedef enum logic [1:0] {
        CMD_SDEC  = 2'd0,
        CMD_UDEC  = 2'd1,
        CMD_LHEX  = 2'd2,
        CMD_UHEX  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic                  load;
        logic                  hex;
        logic [VALUE_BITS-1:0] mag;
    } t_conv_ctrl;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] ndig;
        logic [3:0]       nibble;
    } t_conv_stat;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {3'b000, d};
        end else if (upper) begin
            ch = CH_UPPER_A + {3'b000, d} - 7'd10;
        end else begin
            ch = CH_LOWER_A + {3'b000, d} - 7'd10;
        end
        return ch;
    endfunction

endpackage

@@ rtl/ita_conv_unit.sv @@
// Shared shift and add-3 unit that turns a magnitude into BCD digits one bit per cycle.
// Hex values are loaded as nibbles directly. Depends on ita_pkg.
module ita_conv_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ita_pkg::t_conv_ctrl           i_ctrl,
    input  logic [ita_pkg::SEL_W-1:0]     i_sel,
    output ita_pkg::t_conv_stat           o_stat
);

    logic [ita_pkg::VALUE_BITS-1:0] r_bin;
    logic [ita_pkg::VALUE_BITS-1:0] n_bin;
    logic [ita_pkg::DIG_W-1:0]      r_bcd;
    logic [ita_pkg::DIG_W-1:0]      n_bcd;
    logic [ita_pkg::DIG_W-1:0]      adj;
    logic [ita_pkg::CNT_W-1:0]      r_cnt;
    logic [ita_pkg::CNT_W-1:0]      n_cnt;
    logic [ita_pkg::IDX_W-1:0]      ndig;

    always_comb begin
        for (int k = 0; k < ita_pkg::NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_bin = i_ctrl.mag;
            if (i_ctrl.hex) begin
                n_bcd = ita_pkg::DIG_W'(i_ctrl.mag);
                n_cnt = '0;
            end else begin
                n_bcd = '0;
                n_cnt = ita_pkg::CNT_W'(ita_pkg::VALUE_BITS);
            end
        end else if (r_cnt != '0) begin
            n_bcd = {adj[ita_pkg::DIG_W-2:0], r_bin[ita_pkg::VALUE_BITS-1]};
            n_bin = {r_bin[ita_pkg::VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    always_comb begin
        ndig = ita_pkg::IDX_W'(1);
        for (int k = 1; k < ita_pkg::NUM_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                ndig = ita_pkg::IDX_W'(k + 1);
            end
        end
    end

    assign o_stat.done   = (r_cnt == '0);
    assign o_stat.ndig   = ndig;
    assign o_stat.nibble = r_bcd[{i_sel, 2'b00} +: 4];

endmodule

@@ rtl/ita_out_reg.sv @@
// Output register of the result channel; it holds one character beat until taken.
// Depends on ita_pkg.
module ita_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ita_pkg::t_out_beat i_beat,
    input  logic               i_out_ready,
    output logic               o_free,
    output logic               o_out_valid,
    output ita_pkg::t_out_beat o_out_data
);

    logic               r_valid;
    ita_pkg::t_out_beat r_data;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_data <= i_beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ rtl/integer_to_ascii_converter.sv @@
// Top level of the integer to ASCII converter: sequencer, conversion unit and output register.
// Depends on ita_pkg, ita_conv_unit and ita_out_reg.
//
// An input beat carries a mode and a 32-bit value. The block answers with one output beat
// per character, most significant first, with last set on the final character. Zero gives
// a single '0'; a negative value in signed decimal mode gives '-' and then its magnitude.
// The input is ready only while the block is idle, so one number is handled at a time.
// Decimal numbers pass through a shift and add-3 loop, one bit per cycle; hex numbers
// skip that loop. After that, one character leaves per cycle while the receiver takes
// them. A new input beat is taken once the last character sits in the output register,
// even if the receiver has not yet taken it. When the receiver stalls, the output
// register holds its beat and the sequencer waits. Reset clears the sequencer and the
// output register; the block is then idle and ready.
module integer_to_ascii_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ita_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ita_pkg::t_out_beat o_out_data
);

    ita_pkg::t_state     r_state;
    ita_pkg::t_state     n_state;
    logic                r_neg;
    logic                n_neg;
    logic                r_upper;
    logic                n_upper;
    logic [ita_pkg::IDX_W-1:0] r_idx;
    logic [ita_pkg::IDX_W-1:0] n_idx;
    logic [ita_pkg::IDX_W-1:0] idx_m1;

    ita_pkg::t_conv_ctrl conv_ctrl;
    ita_pkg::t_conv_stat conv_stat;
    ita_pkg::t_out_beat  push_beat;
    ita_pkg::t_cmd       cmd;
    logic [ita_pkg::VALUE_BITS-1:0] raw;
    logic                is_neg;
    logic                push;
    logic                free;

    assign cmd    = ita_pkg::t_cmd'(i_in_data.cmd);
    assign raw    = i_in_data.value[ita_pkg::VALUE_BITS-1:0];
    assign is_neg = (cmd == ita_pkg::CMD_SDEC) && raw[ita_pkg::VALUE_BITS-1];
    assign idx_m1 = r_idx - 1'b1;

    always_comb begin
        n_state         = r_state;
        n_neg           = r_neg;
        n_upper         = r_upper;
        n_idx           = r_idx;
        o_in_ready      = 1'b0;
        push            = 1'b0;
        push_beat       = '0;
        conv_ctrl.load  = 1'b0;
        conv_ctrl.hex   = (cmd == ita_pkg::CMD_LHEX) || (cmd == ita_pkg::CMD_UHEX);
        conv_ctrl.mag   = is_neg ? (~raw + 1'b1) : raw;
        unique case (r_state)
            ita_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    conv_ctrl.load = 1'b1;
                    n_neg          = is_neg;
                    n_upper        = (cmd == ita_pkg::CMD_UHEX);
                    n_state        = ita_pkg::ST_CONV;
                end
            end
            ita_pkg::ST_CONV: begin
                if (conv_stat.done) begin
                    n_idx   = conv_stat.ndig;
                    n_state = ita_pkg::ST_EMIT;
                end
            end
            ita_pkg::ST_EMIT: begin
                if (free) begin
                    push = 1'b1;
                    if (r_neg) begin
                        push_beat.character = ita_pkg::CH_MINUS;
                        push_beat.last      = 1'b0;
                        n_neg               = 1'b0;
                    end else begin
                        push_beat.character = ita_pkg::digit_char(conv_stat.nibble, r_upper);
                        push_beat.last      = (r_idx == ita_pkg::IDX_W'(1));
                        n_idx               = idx_m1;
                        if (r_idx == ita_pkg::IDX_W'(1)) begin
                            n_state = ita_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ita_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ita_pkg::ST_IDLE;
            r_neg   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_idx   <= n_idx;
        end
        r_upper <= n_upper;
    end

    ita_conv_unit u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (conv_ctrl),
        .i_sel   (idx_m1[ita_pkg::SEL_W-1:0]),
        .o_stat  (conv_stat)
    );

    ita_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_beat      (push_beat),
        .i_out_ready (i_out_ready),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_converter: directed and random numbers in all four modes.
// Depends on ita_pkg and the converter RTL; a scoreboard class predicts every character beat.

class char_scoreboard;
    ita_pkg::t_out_beat pending_chars[$];
    int unsigned        failures;

    function new();
        failures = 0;
    endfunction

    function void note_number(ita_pkg::t_in_beat b);
        logic [31:0]        mag;
        int unsigned        base;
        logic [3:0]         d;
        logic               neg;
        logic [6:0]         digs[$];
        logic [6:0]         ch;
        ita_pkg::t_out_beat e;
        neg  = (b.cmd == ita_pkg::CMD_SDEC) && b.value[31];
        mag  = neg ? (~b.value + 32'd1) : b.value;
        base = (b.cmd == ita_pkg::CMD_LHEX || b.cmd == ita_pkg::CMD_UHEX) ? 16 : 10;
        do begin
            d = 4'(mag % base);
            if (d < 4'd10) begin
                ch = ita_pkg::CH_ZERO + {3'b000, d};
            end else if (b.cmd == ita_pkg::CMD_UHEX) begin
                ch = ita_pkg::CH_UPPER_A + {3'b000, d} - 7'd10;
            end else begin
                ch = ita_pkg::CH_LOWER_A + {3'b000, d} - 7'd10;
            end
            digs.push_front(ch);
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            e.character = ita_pkg::CH_MINUS;
            e.last      = 1'b0;
            pending_chars.push_back(e);
        end
        foreach (digs[i]) begin
            e.character = digs[i];
            e.last      = (i == digs.size() - 1);
            pending_chars.push_back(e);
        end
    endfunction

    function void check_char(ita_pkg::t_out_beat got);
        ita_pkg::t_out_beat want;
        if (pending_chars.size() == 0) begin
            $error("unexpected beat: character %0d last %0b", got.character, got.last);
            failures++;
        end else begin
            want = pending_chars.pop_front();
            if (got.character !== want.character) begin
                $error("character: expected %0d, actual %0d", want.character, got.character);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                failures++;
            end
        end
    endfunction
endclass

module testbench;
    import ita_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 89;
    localparam int DRAIN_CYCLES = 60;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_beat  in_data = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    bit             no_idle = 1'b0;
    int unsigned    cycles = 0;
    char_scoreboard board = new();

    integer_to_ascii_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_number(input t_cmd c, input logic [31:0] v);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: c, value: v};
        do @(posedge i_clk); while (!o_in_ready);
        board.note_number(in_data);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int unsigned k;
        int unsigned base;
        case ($urandom_range(0, 4))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom_range(0, 20);
            end
            2: begin
                p    = 32'd1;
                base = $urandom_range(0, 1) ? 16 : 10;
                k    = $urandom_range(0, 9);
                repeat (k) p = p * base;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            3: begin
                return $urandom >> $urandom_range(0, 31);
            end
            default: begin
                return -$urandom_range(1, 20);
            end
        endcase
    endfunction

    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_char(o_out_data);
        end
    end

    initial begin
        logic [31:0] corner[6];
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF, 32'hABCD_EF09};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner[i]) begin
            send_number(CMD_SDEC, corner[i]);
            send_number(CMD_UDEC, corner[i]);
            send_number(CMD_LHEX, corner[i]);
            send_number(CMD_UHEX, corner[i]);
        end

        for (int phase = 0; phase < 5; phase++) begin
            no_idle = (phase == 1);
            if (phase == 3) begin
                in_valid <= 1'b0;
                while (board.pending_chars.size() != 0) @(posedge i_clk);
            end
            repeat (PHASE_ITEMS) send_number(t_cmd'($urandom_range(0, 3)), pick_value());
        end
        in_valid <= 1'b0;

        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending_chars.size() != 0) begin
            $error("%0d expected beats never arrived", board.pending_chars.size());
            board.failures++;
        end
        if (board.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
